FILE: rtl/core/pfe_pkg.sv
package pfe_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int DATA_WIDTH  = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int SP_WIDTH    = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_WIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // ASCII symbols
   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_NINE  = 8'h39;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_SLASH = 8'h2F;
   localparam logic [7:0] SYM_CARET = 8'h5E;

   // error codes
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_UNDER = 3'd1;
   localparam logic [2:0] ERR_OVER  = 3'd2;
   localparam logic [2:0] ERR_DIV0  = 3'd3;
   localparam logic [2:0] ERR_BAD   = 3'd4;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW
   } op_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [2:0]                    error_code;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      op_type                op;
      logic [DATA_WIDTH-1:0] lhs;
      logic [DATA_WIDTH-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic                  done;
      logic                  div_zero;
      logic [DATA_WIDTH-1:0] result;
   } alu_rsp_type;

   // sign-extend or truncate a stack word to the result width
   function automatic logic signed [VALUE_WIDTH-1:0] to_value(input logic [DATA_WIDTH-1:0] v);
      logic signed [VALUE_WIDTH-1:0] r;
      r = '0;
      for (int i = 0; i < VALUE_WIDTH; i++) begin
         if (i < DATA_WIDTH) begin
            r[i] = v[i];
         end else begin
            r[i] = v[DATA_WIDTH-1];
         end
      end
      return r;
   endfunction

   // keep only the first error of an expression
   function automatic logic [2:0] flag_error(input logic [2:0] cur, input logic [2:0] code);
      return (cur == ERR_NONE) ? code : cur;
   endfunction

endpackage

FILE: rtl/core/pfe_ram.sv
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pfe_alu.sv
module pfe_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pfe_pkg::alu_req_type alu_req,
   output pfe_pkg::alu_rsp_type alu_rsp
);

   localparam int W     = pfe_pkg::DATA_WIDTH;
   localparam int CNT_W = (W > 2) ? $clog2(W) : 1;

   typedef enum logic [2:0] {
      A_IDLE,
      A_DIV,
      A_FIX,
      A_POW
   } state_type;

   state_type      state_ff, state_in;
   logic           done_ff, done_in;
   logic           div0_ff, div0_in;
   logic [W-1:0]   result_ff, result_in;
   logic [W-1:0]   num_ff, num_in;     // dividend in, quotient out
   logic [W-1:0]   den_ff, den_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic           neg_ff, neg_in;
   logic [W-1:0]   acc_ff, acc_in;
   logic [W-1:0]   base_ff, base_in;
   logic [W-1:0]   exp_ff, exp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [W-1:0]   mul_a, mul_b;
   logic [2*W-1:0] prod_ab;
   logic [2*W-1:0] prod_sq;
   logic [W:0]     rem_sh;
   logic [W:0]     rem_diff;
   logic [W-1:0]   mag_l, mag_r;

   // one shared product, plus the squaring of the base
   always_comb begin
      if (state_ff == A_POW) begin
         mul_a = acc_ff;
         mul_b = base_ff;
      end else begin
         mul_a = alu_req.lhs;
         mul_b = alu_req.rhs;
      end
   end

   assign prod_ab = mul_a * mul_b;
   assign prod_sq = base_ff * base_ff;

   assign mag_l = alu_req.lhs[W-1] ? (W'(0) - alu_req.lhs) : alu_req.lhs;
   assign mag_r = alu_req.rhs[W-1] ? (W'(0) - alu_req.rhs) : alu_req.rhs;

   // restoring division step
   assign rem_sh   = {rem_ff, num_ff[W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      div0_in   = div0_ff;
      result_in = result_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         A_IDLE: begin
            if (alu_req.start) begin
               div0_in = 1'b0;
               case (alu_req.op)
                  pfe_pkg::OP_ADD: begin
                     result_in = alu_req.lhs + alu_req.rhs;
                     done_in   = 1'b1;
                  end
                  pfe_pkg::OP_SUB: begin
                     result_in = alu_req.lhs - alu_req.rhs;
                     done_in   = 1'b1;
                  end
                  pfe_pkg::OP_MUL: begin
                     result_in = prod_ab[W-1:0];
                     done_in   = 1'b1;
                  end
                  pfe_pkg::OP_DIV: begin
                     if (alu_req.rhs == '0) begin
                        result_in = '0;
                        div0_in   = 1'b1;
                        done_in   = 1'b1;
                     end else begin
                        neg_in   = alu_req.lhs[W-1] ^ alu_req.rhs[W-1];
                        num_in   = mag_l;
                        den_in   = mag_r;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = A_DIV;
                     end
                  end
                  pfe_pkg::OP_POW: begin
                     if (alu_req.rhs[W-1]) begin
                        // negative exponent: only plus or minus one survive
                        if (alu_req.lhs == W'(1)) begin
                           result_in = W'(1);
                        end else if (alu_req.lhs == '1) begin
                           result_in = alu_req.rhs[0] ? '1 : W'(1);
                        end else begin
                           result_in = '0;
                        end
                        done_in = 1'b1;
                     end else begin
                        acc_in   = W'(1);
                        base_in  = alu_req.lhs;
                        exp_in   = alu_req.rhs;
                        state_in = A_POW;
                     end
                  end
                  default: begin
                     result_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         A_DIV: begin
            // one quotient bit per cycle
            if (!rem_diff[W]) begin
               rem_in = rem_diff[W-1:0];
               num_in = {num_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[W-1:0];
               num_in = {num_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(W - 1)) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            result_in = neg_ff ? (W'(0) - num_ff) : num_ff;
            done_in   = 1'b1;
            state_in  = A_IDLE;
         end
         A_POW: begin
            // square and multiply, one exponent bit per cycle
            if (exp_ff == '0) begin
               result_in = acc_ff;
               done_in   = 1'b1;
               state_in  = A_IDLE;
            end else begin
               if (exp_ff[0]) begin
                  acc_in = prod_ab[W-1:0];
               end
               base_in = prod_sq[W-1:0];
               exp_in  = exp_ff >> 1;
            end
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      div0_ff   <= div0_in;
      result_ff <= result_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      cnt_ff    <= cnt_in;
   end

   assign alu_rsp.done     = done_ff;
   assign alu_rsp.div_zero = div0_ff;
   assign alu_rsp.result   = result_ff;

endmodule

FILE: rtl/core/postfix_expression_evaluator_unit.sv
// A digit or a rejected symbol is handled in the idle state, and the last symbol then posts
// the response from the finish state. + - * are computed directly, / runs one quotient bit
// per cycle, and ^ runs one exponent bit per cycle.
// Throughput: one request at a time; the divider sets the worst case, and a last symbol
// waits while the previous response is still stalled.
// Reset clears the stack pointer, the sticky error and the response valid; the stack memory
// is not cleared, as only entries below the stack pointer are ever read.
module postfix_expression_evaluator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfe_pkg::rsp_type rsp_data
);

   localparam int W   = pfe_pkg::DATA_WIDTH;
   localparam int SPW = pfe_pkg::SP_WIDTH;
   localparam int AW  = pfe_pkg::ADDR_WIDTH;

   typedef enum logic [2:0] {
      T_IDLE,
      T_READ,
      T_EXEC,
      T_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic [2:0]       err_ff, err_in;
   logic [W-1:0]     tos_ff, tos_in;
   pfe_pkg::op_type  op_ff, op_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pfe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [W-1:0]     wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [W-1:0]     rd_data;

   pfe_pkg::alu_req_type alu_req;
   pfe_pkg::alu_rsp_type alu_rsp;

   logic             accept;
   logic             out_free;
   logic             is_digit;
   logic [SPW-1:0]   sp_m1;
   logic [SPW-1:0]   sp_m2;
   logic [W-1:0]     digit_val;

   pfe_ram #(
      .WIDTH (W),
      .DEPTH (pfe_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfe_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_digit  = (req_data.symbol >= pfe_pkg::SYM_ZERO) &&
                      (req_data.symbol <= pfe_pkg::SYM_NINE);
   assign sp_m1     = sp_ff - SPW'(1);
   assign sp_m2     = sp_ff - SPW'(2);
   assign digit_val = {{(W - 4){1'b0}}, req_data.symbol[3:0]};

   // left operand comes back from the memory, right operand is the cached top
   assign alu_req.start = (state_ff == T_READ);
   assign alu_req.op    = op_ff;
   assign alu_req.lhs   = rd_data;
   assign alu_req.rhs   = tos_ff;

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      tos_in       = tos_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = sp_ff[AW-1:0];
      wr_data      = digit_val;
      rd_en        = 1'b0;
      rd_addr      = sp_m2[AW-1:0];
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               last_in  = req_data.is_last;
               state_in = req_data.is_last ? T_FIN : T_IDLE;
               if (is_digit) begin
                  // push, or drop on a full stack
                  if (sp_ff >= SPW'(pfe_pkg::STACK_DEPTH)) begin
                     err_in = pfe_pkg::flag_error(err_ff, pfe_pkg::ERR_OVER);
                  end else begin
                     wr_en  = 1'b1;
                     tos_in = digit_val;
                     sp_in  = sp_ff + SPW'(1);
                  end
               end else begin
                  case (req_data.symbol)
                     pfe_pkg::SYM_PLUS:  op_in = pfe_pkg::OP_ADD;
                     pfe_pkg::SYM_MINUS: op_in = pfe_pkg::OP_SUB;
                     pfe_pkg::SYM_STAR:  op_in = pfe_pkg::OP_MUL;
                     pfe_pkg::SYM_SLASH: op_in = pfe_pkg::OP_DIV;
                     pfe_pkg::SYM_CARET: op_in = pfe_pkg::OP_POW;
                     default:            op_in = op_ff;
                  endcase
                  case (req_data.symbol)
                     pfe_pkg::SYM_PLUS, pfe_pkg::SYM_MINUS, pfe_pkg::SYM_STAR,
                     pfe_pkg::SYM_SLASH, pfe_pkg::SYM_CARET: begin
                        if (sp_ff < SPW'(2)) begin
                           err_in = pfe_pkg::flag_error(err_ff, pfe_pkg::ERR_UNDER);
                        end else begin
                           rd_en    = 1'b1;
                           state_in = T_READ;
                        end
                     end
                     default: begin
                        err_in = pfe_pkg::flag_error(err_ff, pfe_pkg::ERR_BAD);
                     end
                  endcase
               end
            end
         end
         T_READ: begin
            state_in = T_EXEC;
         end
         T_EXEC: begin
            // write back over the left operand and pop one
            if (alu_rsp.done) begin
               wr_en   = 1'b1;
               wr_addr = sp_m2[AW-1:0];
               wr_data = alu_rsp.result;
               tos_in  = alu_rsp.result;
               sp_in   = sp_m1;
               if (alu_rsp.div_zero) begin
                  err_in = pfe_pkg::flag_error(err_ff, pfe_pkg::ERR_DIV0);
               end
               state_in = last_ff ? T_FIN : T_IDLE;
            end
         end
         T_FIN: begin
            // post the response once the output register is free, then clear
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sp_ff == '0) begin
                  rsp_data_in.value      = '0;
                  rsp_data_in.error_code = pfe_pkg::flag_error(err_ff, pfe_pkg::ERR_UNDER);
               end else begin
                  rsp_data_in.value      = pfe_pkg::to_value(tos_ff);
                  rsp_data_in.error_code = err_ff;
               end
               sp_in    = '0;
               err_in   = pfe_pkg::ERR_NONE;
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         sp_ff        <= '0;
         err_ff       <= pfe_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff      <= tos_in;
      op_ff       <= op_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the stack pointer never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(pfe_pkg::STACK_DEPTH))
      else $error("stack pointer beyond depth");

   // the arithmetic unit only reports while the controller waits on it
   assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> (state_ff == T_EXEC))
      else $error("arithmetic result outside execute state");

   // posting a response empties the stack and clears the error
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_FIN && out_free) |=> (sp_ff == '0 && err_ff == pfe_pkg::ERR_NONE
                                           && rsp_valid_ff))
      else $error("stack not cleared after response");

   // an operator only starts with two operands on the stack
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_READ) |-> (sp_ff >= SPW'(2)))
      else $error("operator started with too few operands");

endmodule
